/* src/fol_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fol_pkg: shared types and constants for the frequency ordered list
// Fixed widths of the result fields and the result word type.
// ----------------------------------------------------------------------------
package fol_pkg;

    // Fixed port widths of the input and result words
    localparam int KEY_IN_W  = 16;
    localparam int RANK_W    = 6;
    localparam int USE_W     = 16;
    localparam int ENTRIES_W = 7;

    // One result word
    typedef struct packed {
        logic                 hit;
        logic                 dropped;
        logic [RANK_W-1:0]    rank;
        logic [USE_W-1:0]     use_count;
        logic [ENTRIES_W-1:0] entries_used;
    } res_t;

endpackage

/* src/frequency_ordered_list.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frequency_ordered_list: key list ranked by access count
// Searches the occupied ranks for a key, bumps its count on a hit and moves
// it forward past predecessors with an equal or lower count; appends on miss,
// or drops the key on a miss when the list is full.
// Search and move: both walk the entry RAM one rank per cycle through its
//   single read port; the move runs only on a hit past rank 0. One word is
//   in work at a time.
// Reset: control state and occupancy clear at once; the entry RAM is not
//   cleared, since only ranks below occupancy are ever read.
module frequency_ordered_list
    import fol_pkg::*;
#(
    parameter int LIST_DEPTH = 64,
    parameter int KEY_BITS   = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [KEY_IN_W-1:0]  key_id,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic                 dropped,
    output logic [RANK_W-1:0]    rank,
    output logic [USE_W-1:0]     use_count,
    output logic [ENTRIES_W-1:0] entries_used
);

    localparam int AW     = $clog2(LIST_DEPTH);
    localparam int OW     = $clog2(LIST_DEPTH + 1);
    localparam int DW     = KEY_BITS + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_BUBBLE = 3'd2;
    localparam logic [2:0] S_PLACE  = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [OW-1:0]         occ_reg, occ_next;
    res_t                  res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    res_t                  out_res_reg, out_res_next;

    logic                  rd_en, wr_en;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic [KEY_BITS-1:0]   wr_key;
    logic [COUNT_BITS-1:0] wr_cnt;
    logic [DW-1:0]         rd_data;
    logic [KEY_BITS-1:0]   rd_key;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [COUNT_BITS-1:0] cnt_sat;
    logic                  last_idx, list_full, out_free;

    // Entry RAM: {key, count} by rank
    fol_ram #(
        .DEPTH  (LIST_DEPTH),
        .DATA_W (DW),
        .ADDR_W (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({wr_key, wr_cnt}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key    = rd_data[DW-1:COUNT_BITS];
    assign rd_cnt    = rd_data[COUNT_BITS-1:0];
    assign cnt_sat   = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
    assign last_idx  = (OW'(idx_reg) + OW'(1)) == occ_reg;
    assign list_full = occ_reg == OW'(LIST_DEPTH);
    assign out_free  = !out_valid_reg || out_ready;

    // Sequencer: search, move forward, append or drop
    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        occ_next       = occ_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_key         = key_reg;
        wr_cnt         = cnt_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next = KEY_BITS'(key_id);
                    if (occ_reg == '0)
                    begin
                        // Empty list: append at rank 0
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        wr_key   = KEY_BITS'(key_id);
                        wr_cnt   = '0;
                        occ_next = OW'(1);
                        res_next = '{hit: 1'b0, dropped: 1'b0, rank: '0,
                                     use_count: '0, entries_used: ENTRIES_W'(1)};
                        state_next = S_FIN;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        idx_next   = '0;
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                if (rd_key == key_reg)
                begin
                    res_next.hit          = 1'b1;
                    res_next.dropped      = 1'b0;
                    res_next.use_count    = USE_W'(cnt_sat);
                    res_next.entries_used = ENTRIES_W'(occ_reg);
                    cnt_next              = cnt_sat;
                    if (idx_reg == '0)
                    begin
                        wr_en         = 1'b1;
                        wr_cnt        = cnt_sat;
                        res_next.rank = '0;
                        state_next    = S_FIN;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = idx_reg - AW'(1);
                        state_next = S_BUBBLE;
                    end
                end
                else if (last_idx)
                begin
                    if (list_full)
                    begin
                        res_next = '{hit: 1'b0, dropped: 1'b1, rank: '0,
                                     use_count: '0, entries_used: ENTRIES_W'(occ_reg)};
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = occ_reg[AW-1:0];
                        wr_cnt   = '0;
                        occ_next = occ_reg + OW'(1);
                        res_next = '{hit: 1'b0, dropped: 1'b0, rank: RANK_W'(occ_reg),
                                     use_count: '0,
                                     entries_used: ENTRIES_W'(occ_reg + OW'(1))};
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
            end

            S_BUBBLE:
            begin
                // Read data holds the entry one rank ahead
                wr_en = 1'b1;
                if (rd_cnt <= cnt_reg)
                begin
                    wr_key   = rd_key;
                    wr_cnt   = rd_cnt;
                    idx_next = idx_reg - AW'(1);
                    if (idx_reg == AW'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = idx_reg - AW'(2);
                    end
                end
                else
                begin
                    res_next.rank = RANK_W'(idx_reg);
                    state_next    = S_FIN;
                end
            end

            S_PLACE:
            begin
                wr_en         = 1'b1;
                res_next.rank = RANK_W'(idx_reg);
                state_next    = S_FIN;
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        res_reg     <= res_next;
        out_res_reg <= out_res_next;
    end

    assign in_ready     = state_reg == S_IDLE;
    assign out_valid    = out_valid_reg;
    assign hit          = out_res_reg.hit;
    assign dropped      = out_res_reg.dropped;
    assign rank         = out_res_reg.rank;
    assign use_count    = out_res_reg.use_count;
    assign entries_used = out_res_reg.entries_used;

    // Checks
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OW'(LIST_DEPTH))
        else $error("occupancy above list depth");

    a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> OW'(idx_reg) < occ_reg)
        else $error("search index beyond occupancy");

    a_bubble_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BUBBLE |-> idx_reg != '0)
        else $error("move step at rank zero");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg != S_IDLE)
        else $error("accepted word did not start work");

    a_hit_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && dropped))
        else $error("result both hit and dropped");

endmodule

/* src/fol_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fol_ram: simple dual port synchronous RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fol_ram #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 32,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* tb/sv/tb_frequency_ordered_list.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frequency_ordered_list: self-checking bench for the frequency ordered list
// Drives key words through the valid/ready input, keeps its own ranked copy of
// the list to predict every result word, and checks each result field by
// field. Covers appends, hits with forward moves, equal counts, and a full
// list with dropped keys, under varying stalls on both sides.
// ----------------------------------------------------------------------------
module tb_frequency_ordered_list
    import fol_pkg::*;
();

    localparam int LIST_DEPTH = 64;
    localparam int KEY_BITS   = 16;
    localparam int COUNT_BITS = 16;
    localparam logic [USE_W-1:0] COUNT_MAX = '1;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [KEY_IN_W-1:0]  key_id = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 hit;
    logic                 dropped;
    logic [RANK_W-1:0]    rank;
    logic [USE_W-1:0]     use_count;
    logic [ENTRIES_W-1:0] entries_used;

    // Shadow copy of the ranked list
    logic [KEY_IN_W-1:0] shadow_key   [0:LIST_DEPTH-1];
    logic [USE_W-1:0]    shadow_count [0:LIST_DEPTH-1];
    int                  shadow_used = 0;

    res_t pending_results[$];
    int   mismatch_count = 0;
    int   result_index = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;

    frequency_ordered_list #(
        .LIST_DEPTH (LIST_DEPTH),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .key_id       (key_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .dropped      (dropped),
        .rank         (rank),
        .use_count    (use_count),
        .entries_used (entries_used)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Run limit
    initial
    begin
        #(64'd2_000_000_000);
        $display("tb_frequency_ordered_list: done, errors");
        $finish;
    end

    // Lowest rank holding the key, -1 if absent
    function automatic int rank_of(input logic [KEY_IN_W-1:0] k);
        int i;
        for (i = 0; i < shadow_used; i++)
        begin
            if (shadow_key[i] == k)
                return i;
        end
        return -1;
    endfunction

    // Key not currently in the list
    function automatic logic [KEY_IN_W-1:0] fresh_key();
        logic [KEY_IN_W-1:0] k;
        k = KEY_IN_W'($urandom());
        while (rank_of(k) >= 0)
            k = KEY_IN_W'($urandom());
        return k;
    endfunction

    // Apply one access to the shadow list and build the result word
    function automatic res_t predict_access(input logic [KEY_IN_W-1:0] k);
        res_t                r;
        int                  pos;
        logic [KEY_IN_W-1:0] tk;
        logic [USE_W-1:0]    tc;
        r = '0;
        pos = rank_of(k);
        if (pos >= 0)
        begin
            if (shadow_count[pos] != COUNT_MAX)
                shadow_count[pos] = shadow_count[pos] + 1'b1;
            r.use_count = shadow_count[pos];
            // move forward past equal or lower counts
            while (pos != 0 && shadow_count[pos-1] <= shadow_count[pos])
            begin
                tk = shadow_key[pos-1];
                tc = shadow_count[pos-1];
                shadow_key[pos-1]   = shadow_key[pos];
                shadow_count[pos-1] = shadow_count[pos];
                shadow_key[pos]     = tk;
                shadow_count[pos]   = tc;
                pos--;
            end
            r.hit          = 1'b1;
            r.rank         = RANK_W'(pos);
            r.entries_used = ENTRIES_W'(shadow_used);
        end
        else if (shadow_used < LIST_DEPTH)
        begin
            shadow_key[shadow_used]   = k;
            shadow_count[shadow_used] = '0;
            r.rank = RANK_W'(shadow_used);
            shadow_used++;
            r.entries_used = ENTRIES_W'(shadow_used);
        end
        else
        begin
            // full list: key dropped, list unchanged
            r.dropped      = 1'b1;
            r.entries_used = ENTRIES_W'(shadow_used);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input longint unsigned got,
                               input longint unsigned want);
        if (got != want)
            report_mismatch($sformatf("result %0d: %s got %0h, want %0h",
                                      result_index, name, got, want));
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Send one key word; predict its result at acceptance
    task automatic send_key(input logic [KEY_IN_W-1:0] k);
        res_t want;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        key_id   <= k;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = predict_access(k);
        pending_results.push_back(want);
    endtask

    // Result receiver and checker
    always @(posedge clk)
    begin
        res_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d: word with none expected",
                                              result_index));
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("hit", hit, want.hit);
                    check_field("dropped", dropped, want.dropped);
                    check_field("rank", rank, want.rank);
                    check_field("use_count", use_count, want.use_count);
                    check_field("entries_used", entries_used, want.entries_used);
                end
                result_index++;
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Extremes, appends, forward moves and equal counts on a short list
    task automatic test_directed_keys();
        send_key(16'h0000);     // append at rank 0
        send_key(16'hFFFF);     // append at rank 1
        send_key(16'hFFFF);     // hit, passes a lower count
        send_key(16'h0000);     // hit, passes an equal count
        send_key(16'h0000);
        send_key(16'h5555);
        send_key(16'hAAAA);
        send_key(16'hAAAA);     // passes two, stops behind a higher count
        send_key(16'h8000);
        send_key(16'h0001);
        send_key(16'h7FFF);
        send_key(16'hFFFE);
        send_key(16'h0001);     // hit from rank 5
        send_key(16'h0001);
        send_key(16'h0001);     // now ahead of everything
        send_key(16'h8000);
        send_key(16'hFFFF);
        send_key(16'h7FFF);
    endtask

    // Fill to capacity, then deep hits and dropped keys
    task automatic test_fill_and_drop();
        int i;
        while (shadow_used < LIST_DEPTH)
            send_key(fresh_key());
        send_key(shadow_key[LIST_DEPTH-1]);   // deepest search
        for (i = 0; i < 3; i++)
            send_key(fresh_key());            // dropped
        send_key(shadow_key[0]);
        send_key(shadow_key[LIST_DEPTH-1]);
        send_key(fresh_key());
    endtask

    // Mostly hits on present keys, plus new keys and extreme values
    task automatic test_random_accesses(input int count);
        int                  i;
        int                  pick;
        logic [KEY_IN_W-1:0] k;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65 && shadow_used > 0)
                k = shadow_key[$urandom_range(0, shadow_used - 1)];
            else if (pick < 90)
                k = KEY_IN_W'($urandom());
            else
                k = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            send_key(k);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(35, 63);
        test_directed_keys();
        test_random_accesses(350);
        test_fill_and_drop();

        set_idling(63, 35);
        test_random_accesses(400);

        set_idling(0, 0);
        test_random_accesses(400);

        // drain
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3 * LIST_DEPTH) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb_frequency_ordered_list: done, clean");
        else
            $display("tb_frequency_ordered_list: done, errors");
        $finish;
    end

endmodule
